[sv/dvfc_pkg.sv]
`timescale 1ns / 1ps

package dvfc_pkg;

   localparam int ENTRIES    = 16;
   localparam int COUNT_BITS = 16;
   localparam int VALUE_BITS = 32;
   localparam int OCC_BITS   = 16;

   localparam int IDX_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int FILL_BITS = $clog2(ENTRIES + 1);
   localparam int WIDE_BITS = (COUNT_BITS > OCC_BITS) ? COUNT_BITS : OCC_BITS;

   localparam int REQ_DATA_BITS = VALUE_BITS;
   localparam int RSP_DATA_BITS = ((VALUE_BITS + OCC_BITS + 7) / 8) * 8;

   typedef logic signed [VALUE_BITS-1:0] value_type;
   typedef logic [COUNT_BITS-1:0]        count_type;
   typedef logic [OCC_BITS-1:0]          occ_type;
   typedef logic [IDX_BITS-1:0]          idx_type;
   typedef logic [FILL_BITS-1:0]         fill_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_INSERT,
      ST_EMIT_RD,
      ST_EMIT_LD
   } state_type;

   typedef struct packed {
      logic      value_en;
      logic      count_en;
      idx_type   addr;
      value_type value;
      count_type count;
   } tbl_wr_type;

   typedef struct packed {
      logic    en;
      idx_type addr;
   } tbl_rd_type;

   typedef struct packed {
      value_type value;
      count_type count;
   } tbl_data_type;

   typedef struct packed {
      logic      hit;
      count_type count_next;
   } match_type;

   // clamp a stored count to the reported field width
   function automatic occ_type occ_report(input count_type count);
      logic [WIDE_BITS-1:0] wide;
      wide = WIDE_BITS'(count);
      if (wide > WIDE_BITS'({OCC_BITS{1'b1}})) begin
         occ_report = {OCC_BITS{1'b1}};
      end else begin
         occ_report = wide[OCC_BITS-1:0];
      end
   endfunction

endpackage

[sv/dvfc_table.sv]
`timescale 1ns / 1ps

module dvfc_table (
   input  logic                  clock,
   input  dvfc_pkg::tbl_wr_type  wr,
   input  dvfc_pkg::tbl_rd_type  rd,
   output dvfc_pkg::tbl_data_type rd_data
);

   dvfc_pkg::value_type value_mem [dvfc_pkg::ENTRIES];
   dvfc_pkg::count_type count_mem [dvfc_pkg::ENTRIES];
   dvfc_pkg::tbl_data_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.value_en) begin
         value_mem[wr.addr] <= wr.value;
      end
      if (wr.count_en) begin
         count_mem[wr.addr] <= wr.count;
      end
   end

   // read data only moves when a read is issued, so it holds for the emit stall
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff.value <= value_mem[rd.addr];
         rd_data_ff.count <= count_mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/dvfc_match.sv]
`timescale 1ns / 1ps

module dvfc_match (
   input  dvfc_pkg::value_type    key,
   input  dvfc_pkg::tbl_data_type entry,
   output dvfc_pkg::match_type    result
);

   always_comb begin
      result.hit = (entry.value == key);
      // saturating increment
      if (&entry.count) begin
         result.count_next = entry.count;
      end else begin
         result.count_next = entry.count + dvfc_pkg::COUNT_BITS'(1);
      end
   end

endmodule

[sv/dvfc_seq.sv]
`timescale 1ns / 1ps

module dvfc_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  dvfc_pkg::value_type    req_value,
   input  logic                   req_last,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output dvfc_pkg::value_type    rsp_value,
   output dvfc_pkg::occ_type      rsp_occ,
   output logic                   rsp_overflow,
   output logic                   rsp_last,
   output dvfc_pkg::tbl_wr_type   wr,
   output dvfc_pkg::tbl_rd_type   rd,
   input  dvfc_pkg::tbl_data_type rd_data,
   output dvfc_pkg::value_type    key,
   input  dvfc_pkg::match_type    mres
);

   dvfc_pkg::state_type state_ff, state_in;
   dvfc_pkg::value_type key_ff, key_in;
   logic                last_ff, last_in;
   dvfc_pkg::fill_type  idx_ff, idx_in;
   dvfc_pkg::fill_type  fill_ff, fill_in;
   logic                ovf_ff, ovf_in;

   logic                rsp_valid_ff, rsp_valid_in;
   dvfc_pkg::value_type rsp_value_ff, rsp_value_in;
   dvfc_pkg::occ_type   rsp_occ_ff, rsp_occ_in;
   logic                rsp_ovf_ff, rsp_ovf_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                out_free;
   logic                idx_at_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dvfc_pkg::ST_IDLE;
         fill_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      last_ff      <= last_in;
      idx_ff       <= idx_in;
      rsp_value_ff <= rsp_value_in;
      rsp_occ_ff   <= rsp_occ_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign idx_at_end = ((idx_ff + dvfc_pkg::FILL_BITS'(1)) == fill_ff);

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      last_in      = last_ff;
      idx_in       = idx_ff;
      fill_in      = fill_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_occ_in   = rsp_occ_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_last_in  = rsp_last_ff;
      req_tready   = 1'b0;
      wr           = '0;
      rd.en        = 1'b0;
      rd.addr      = idx_ff[dvfc_pkg::IDX_BITS-1:0];

      unique case (state_ff)
         dvfc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               key_in  = req_value;
               last_in = req_last;
               idx_in  = '0;
               rd.en   = 1'b1;
               rd.addr = '0;
               if (fill_ff == '0) begin
                  state_in = dvfc_pkg::ST_INSERT;
               end else begin
                  state_in = dvfc_pkg::ST_SCAN;
               end
            end
         end
         // one used entry compared per cycle
         dvfc_pkg::ST_SCAN: begin
            if (mres.hit) begin
               wr.count_en = 1'b1;
               wr.addr     = idx_ff[dvfc_pkg::IDX_BITS-1:0];
               wr.count    = mres.count_next;
               idx_in      = '0;
               state_in    = last_ff ? dvfc_pkg::ST_EMIT_RD : dvfc_pkg::ST_IDLE;
            end else if (idx_at_end) begin
               state_in = dvfc_pkg::ST_INSERT;
            end else begin
               idx_in  = idx_ff + dvfc_pkg::FILL_BITS'(1);
               rd.en   = 1'b1;
               rd.addr = idx_in[dvfc_pkg::IDX_BITS-1:0];
            end
         end
         dvfc_pkg::ST_INSERT: begin
            if (fill_ff != dvfc_pkg::FILL_BITS'(dvfc_pkg::ENTRIES)) begin
               wr.value_en = 1'b1;
               wr.count_en = 1'b1;
               wr.addr     = fill_ff[dvfc_pkg::IDX_BITS-1:0];
               wr.value    = key_ff;
               wr.count    = dvfc_pkg::COUNT_BITS'(1);
               fill_in     = fill_ff + dvfc_pkg::FILL_BITS'(1);
            end else begin
               ovf_in = 1'b1;
            end
            idx_in   = '0;
            state_in = last_ff ? dvfc_pkg::ST_EMIT_RD : dvfc_pkg::ST_IDLE;
         end
         dvfc_pkg::ST_EMIT_RD: begin
            rd.en    = 1'b1;
            state_in = dvfc_pkg::ST_EMIT_LD;
         end
         dvfc_pkg::ST_EMIT_LD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = rd_data.value;
               rsp_occ_in   = dvfc_pkg::occ_report(rd_data.count);
               rsp_ovf_in   = ovf_ff;
               rsp_last_in  = idx_at_end;
               if (idx_at_end) begin
                  // batch done, table starts over empty
                  fill_in  = '0;
                  ovf_in   = 1'b0;
                  state_in = dvfc_pkg::ST_IDLE;
               end else begin
                  idx_in   = idx_ff + dvfc_pkg::FILL_BITS'(1);
                  state_in = dvfc_pkg::ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = dvfc_pkg::ST_IDLE;
         end
      endcase
   end

   assign key          = key_ff;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_occ      = rsp_occ_ff;
   assign rsp_overflow = rsp_ovf_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

[sv/distinct_value_frequency_counter_unit.sv]
`timescale 1ns / 1ps

// Counts the distinct values of a batch in order of first appearance. Each input beat
// carries one signed 32-bit value and tlast on the final value of the batch. A value is
// compared against the used table entries one entry per cycle by a single compare and
// increment unit, and a new value is not taken until the last one is counted, inserted
// or dropped. After the batch's last beat the table is read out one entry at a time,
// waiting while the result side stalls; req_tready stays low until the readout ends.
// Each result beat gives value and count (saturating at 65535), tuser flags a batch in
// which a new value was dropped because all 16 entries were taken, and tlast marks the
// final result. The table is empty again after the readout and after reset.
module distinct_value_frequency_counter_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [dvfc_pkg::REQ_DATA_BITS-1:0]  req_tdata,   // value[31:0]
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [dvfc_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,   // distinct_value, occurrences
   output logic                                rsp_tuser,   // table_overflow
   output logic                                rsp_tlast
);

   dvfc_pkg::tbl_wr_type   wr;
   dvfc_pkg::tbl_rd_type   rd;
   dvfc_pkg::tbl_data_type rd_data;
   dvfc_pkg::match_type    mres;
   dvfc_pkg::value_type    key;
   dvfc_pkg::value_type    rsp_value;
   dvfc_pkg::occ_type      rsp_occ;

   dvfc_table u_table (
      .clock   (clock),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rd_data)
   );

   dvfc_match u_match (
      .key    (key),
      .entry  (rd_data),
      .result (mres)
   );

   dvfc_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_value    (req_tdata[dvfc_pkg::VALUE_BITS-1:0]),
      .req_last     (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_value    (rsp_value),
      .rsp_occ      (rsp_occ),
      .rsp_overflow (rsp_tuser),
      .rsp_last     (rsp_tlast),
      .wr           (wr),
      .rd           (rd),
      .rd_data      (rd_data),
      .key          (key),
      .mres         (mres)
   );

   assign rsp_tdata = dvfc_pkg::RSP_DATA_BITS'({rsp_occ, rsp_value});

endmodule

[sv/dvfc_checker.sv]
`timescale 1ns / 1ps

module dvfc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [dvfc_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input logic                                rsp_tuser,
   input logic                                rsp_tlast
);

   // no result left over from before reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // an accepted value keeps the block busy while it is compared or inserted
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken on back-to-back cycles");

   // every reported entry was seen at least once
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[dvfc_pkg::VALUE_BITS +: dvfc_pkg::OCC_BITS] != '0)
      else $error("zero occurrence count");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

endmodule

bind distinct_value_frequency_counter_unit dvfc_checker u_dvfc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

[dv/distinct_value_frequency_counter_unit_tb.sv]
`timescale 1ns / 1ps

module distinct_value_frequency_counter_unit_tb;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 30;
   localparam int PHASE_ITEMS     = 100;
   localparam int N_ROWS          = 18;

   typedef struct packed {
      dvfc_pkg::value_type distinct_value;
      dvfc_pkg::occ_type   occurrences;
      logic                table_overflow;
      logic                final_result;
   } tally_beat_type;

   // directed row: reps beats of value, value + step, ...; batch_end only on the final one
   typedef struct packed {
      dvfc_pkg::value_type value;
      logic                last;
      int                  reps;
      int                  step;
      logic                typed;
      tally_beat_type      exp;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [dvfc_pkg::REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                               req_tlast = 1'b0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [dvfc_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic                               rsp_tuser;
   logic                               rsp_tlast;

   // predictor state
   dvfc_pkg::value_type slot_value [dvfc_pkg::ENTRIES];
   dvfc_pkg::count_type slot_count [dvfc_pkg::ENTRIES];
   logic                slot_used  [dvfc_pkg::ENTRIES];
   logic                table_dropped;

   tally_beat_type expected_tallies[$];

   int fail_count     = 0;
   int items_sent     = 0;
   int tallies_seen   = 0;
   int batches_seen   = 0;
   int dropped_seen   = 0;
   int quiet_cycles   = 0;
   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   logic hold_rsp_req = 1'b0;

   int send_pcts  [4] = '{0, 46, 0, 27};
   int stall_pcts [4] = '{0, 0, 46, 27};

   stim_row_type directed_rows [0:N_ROWS-1] = '{
      '{32'sh7FFF_FFFF, 1'b1, 1, 0, 1'b1, '{32'sh7FFF_FFFF, 16'd1, 1'b0, 1'b1}},
      '{32'sh8000_0000, 1'b1, 1, 0, 1'b1, '{32'sh8000_0000, 16'd1, 1'b0, 1'b1}},
      '{32'sh0000_0000, 1'b1, 1, 0, 1'b1, '{32'sh0000_0000, 16'd1, 1'b0, 1'b1}},
      '{32'shFFFF_FFFF, 1'b1, 1, 0, 1'b1, '{32'shFFFF_FFFF, 16'd1, 1'b0, 1'b1}},
      // zero is a real value, never an empty slot
      '{32'sh0000_0000, 1'b0, 3, 0, 1'b0, '0},
      '{32'shFFFF_FFFF, 1'b0, 1, 0, 1'b0, '0},
      '{32'sh0000_0000, 1'b1, 1, 0, 1'b0, '0},
      // exactly full, nothing dropped
      '{32'sd1000,      1'b0, 15, 3, 1'b0, '0},
      '{32'sd2000,      1'b1, 1, 0, 1'b0, '0},
      // full table drops a new value mid batch
      '{32'sd100,       1'b0, 16, 1, 1'b0, '0},
      '{32'sd200,       1'b0, 1, 0, 1'b0, '0},
      '{32'sd105,       1'b1, 1, 0, 1'b0, '0},
      // batch end itself dropped
      '{32'sd300,       1'b0, 16, -1, 1'b0, '0},
      '{32'sh5555_5555, 1'b1, 1, 0, 1'b0, '0},
      // repeats of one value, then the table starts over
      '{32'sd5,         1'b1, 3, 0, 1'b1, '{32'sd5, 16'd3, 1'b0, 1'b1}},
      '{32'sd5,         1'b1, 1, 0, 1'b1, '{32'sd5, 16'd1, 1'b0, 1'b1}},
      '{32'shAAAA_AAAA, 1'b0, 2, 0, 1'b0, '0},
      '{32'sh5555_5555, 1'b1, 1, 0, 1'b0, '0}
   };

   distinct_value_frequency_counter_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      for (int i = 0; i < dvfc_pkg::ENTRIES; i++) begin
         slot_value[i] = '0;
         slot_count[i] = '0;
         slot_used[i]  = 1'b0;
      end
      table_dropped = 1'b0;
   end

   // count one value; on batch end queue one tally per used slot and empty the table
   function automatic void tally_value(input dvfc_pkg::value_type v, input logic last);
      logic           placed;
      int             used;
      int             k;
      tally_beat_type beat;
      placed = 1'b0;
      for (int i = 0; i < dvfc_pkg::ENTRIES && !placed; i++) begin
         if (!slot_used[i]) begin
            slot_used[i]  = 1'b1;
            slot_value[i] = v;
            slot_count[i] = dvfc_pkg::count_type'(1);
            placed        = 1'b1;
         end else if (slot_value[i] == v) begin
            if (slot_count[i] != '1) begin
               slot_count[i] = slot_count[i] + 1'b1;
            end
            placed = 1'b1;
         end
      end
      if (!placed) begin
         table_dropped = 1'b1;
      end
      if (!last) begin
         return;
      end
      used = 0;
      for (int i = 0; i < dvfc_pkg::ENTRIES; i++) begin
         if (slot_used[i]) begin
            used++;
         end
      end
      k = 0;
      for (int i = 0; i < dvfc_pkg::ENTRIES; i++) begin
         if (slot_used[i]) begin
            beat.distinct_value = slot_value[i];
            if (dvfc_pkg::COUNT_BITS > dvfc_pkg::OCC_BITS &&
                slot_count[i] > dvfc_pkg::count_type'({dvfc_pkg::OCC_BITS{1'b1}})) begin
               beat.occurrences = '1;
            end else begin
               beat.occurrences = dvfc_pkg::OCC_BITS'(slot_count[i]);
            end
            beat.table_overflow = table_dropped;
            beat.final_result   = (k + 1 == used);
            expected_tallies.push_back(beat);
            k++;
         end
         slot_used[i]  = 1'b0;
         slot_count[i] = '0;
      end
      table_dropped = 1'b0;
   endfunction

   task automatic put_item(input dvfc_pkg::value_type v, input logic last, input logic typed,
                           input tally_beat_type typed_beat);
      int n_before;
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      n_before = expected_tallies.size();
      tally_value(v, last);
      if (typed && last) begin
         while (expected_tallies.size() > n_before) begin
            void'(expected_tallies.pop_back());
         end
         expected_tallies.push_back(typed_beat);
      end
      items_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic dvfc_pkg::value_type draw_value();
      dvfc_pkg::value_type v;
      case ($urandom_range(0, 3))
         0: v = dvfc_pkg::value_type'($urandom_range(0, 15)) - dvfc_pkg::value_type'(8);
         1: begin
            case ($urandom_range(0, 3))
               0: v = 32'sh7FFF_FFFF;
               1: v = 32'sh8000_0000;
               2: v = 32'sh0000_0000;
               default: v = 32'shFFFF_FFFF;
            endcase
         end
         default: v = dvfc_pkg::value_type'($urandom);
      endcase
      return v;
   endfunction

   // batches drawn from a small pool so values repeat; long batches and big pools can overflow
   task automatic send_random_batches(input int items_wanted);
      dvfc_pkg::value_type pool [20];
      int                  pool_n;
      int                  len;
      int                  start;
      dvfc_pkg::value_type v;
      start = items_sent;
      while (items_sent - start < items_wanted) begin
         pool_n = $urandom_range(1, 18);
         for (int i = 0; i < pool_n; i++) begin
            pool[i] = draw_value();
         end
         if ($urandom_range(0, 7) == 0) begin
            len = $urandom_range(17, 40);
         end else begin
            len = $urandom_range(1, 16);
         end
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(9) == 0) begin
               v = dvfc_pkg::value_type'($urandom);
            end else begin
               v = pool[$urandom_range(0, pool_n - 1)];
            end
            put_item(v, i == len - 1, 1'b0, '0);
         end
      end
   endtask

   // receiver readiness, with one long hold-off when the random phases begin
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp_req) begin
            hold_rsp_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      tally_beat_type      want;
      dvfc_pkg::value_type got_value;
      dvfc_pkg::occ_type   got_occ;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_value = dvfc_pkg::value_type'(rsp_tdata[dvfc_pkg::VALUE_BITS-1:0]);
         got_occ   = rsp_tdata[dvfc_pkg::VALUE_BITS +: dvfc_pkg::OCC_BITS];
         tallies_seen++;
         if (rsp_tlast) begin
            batches_seen++;
            if (rsp_tuser) begin
               dropped_seen++;
            end
         end
         if (expected_tallies.size() == 0) begin
            $error("unexpected result beat: distinct_value %0d occurrences %0d",
                   got_value, got_occ);
            fail_count++;
         end else begin
            want = expected_tallies.pop_front();
            if (got_value != want.distinct_value) begin
               $error("distinct_value: expected %0d, actual %0d", want.distinct_value,
                      got_value);
               fail_count++;
            end
            if (got_occ != want.occurrences) begin
               $error("occurrences: expected %0d, actual %0d", want.occurrences, got_occ);
               fail_count++;
            end
            if (rsp_tuser != want.table_overflow) begin
               $error("table_overflow: expected %0b, actual %0b", want.table_overflow,
                      rsp_tuser);
               fail_count++;
            end
            if (rsp_tlast != want.final_result) begin
               $error("final_result: expected %0b, actual %0b", want.final_result, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin
      stim_row_type row;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < N_ROWS; r++) begin
         row = directed_rows[r];
         for (int k = 0; k < row.reps; k++) begin
            put_item(row.value + dvfc_pkg::value_type'(k * row.step),
                     row.last && (k == row.reps - 1), row.typed, row.exp);
         end
      end

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = send_pcts[p];
         rsp_stall_pct = stall_pcts[p];
         // sender keeps offering while the result side is held off
         if (p == 0) begin
            hold_rsp_req = 1'b1;
         end
         send_random_batches(PHASE_ITEMS);
      end
      req_tvalid <= 1'b0;

      while (expected_tallies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d values, checked %0d tallies over %0d batches", items_sent,
               tallies_seen, batches_seen);
      $display("%0d batches dropped a new value on a full table", dropped_seen);
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
